@@ hdl/spmq_pkg.sv @@
// Shared types, codes and constants of the strict priority multi queue.
`timescale 1ns / 1ps

package spmq_pkg;

  // Fixed widths of the word fields.
  localparam int OPCODE_W      = 2;
  localparam int LINE_SEL_W    = 2;
  localparam int TICKET_W      = 16;
  localparam int LINE_COUNT_W  = 5;
  localparam int TOTAL_COUNT_W = 6;

  // Default sizing of the queue store.
  localparam int NUM_LINES_DEF   = 3;
  localparam int LINE_DEPTH_DEF  = 16;
  localparam int TICKET_BITS_DEF = 16;

  // Depths of the internal buffers.
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  // Request opcodes.
  localparam logic [OPCODE_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_PRIO = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_IDLE = 2'd3;

  // Command kinds handed from the front to the back.
  localparam logic [1:0] KIND_NOP  = 2'd0;
  localparam logic [1:0] KIND_ENQ  = 2'd1;
  localparam logic [1:0] KIND_DEQ  = 2'd2;
  localparam logic [1:0] KIND_PRIO = 2'd3;

  typedef struct packed {
    logic [OPCODE_W-1:0]   opcode;
    logic [LINE_SEL_W-1:0] line_select;
    logic [TICKET_W-1:0]   ticket;
  } req_t;

  typedef struct packed {
    logic                     served_valid;
    logic [TICKET_W-1:0]      served_ticket;
    logic [LINE_SEL_W-1:0]    served_line;
    logic                     overflow;
    logic [LINE_COUNT_W-1:0]  line_count;
    logic [TOTAL_COUNT_W-1:0] total_count;
  } rsp_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [LINE_SEL_W-1:0] line;
    logic [TICKET_W-1:0]   ticket;
  } cmd_t;

endpackage

@@ hdl/spmq_front.sv @@
// Request decoder: classifies each incoming word into a command for the back end.
`timescale 1ns / 1ps

module spmq_front #(
  parameter int NUM_LINES = spmq_pkg::NUM_LINES_DEF
) (
  input  spmq_pkg::req_t req,
  output spmq_pkg::cmd_t cmd
);

  logic in_range;

  assign in_range = ({30'd0, req.line_select} < 32'(NUM_LINES));

  always_comb begin
    cmd.ticket = req.ticket;
    cmd.line   = req.line_select;
    cmd.kind   = spmq_pkg::KIND_NOP;
    unique case (req.opcode)
      spmq_pkg::OP_ENQ: begin
        cmd.kind = in_range ? spmq_pkg::KIND_ENQ : spmq_pkg::KIND_NOP;
      end
      spmq_pkg::OP_DEQ: begin
        cmd.kind = in_range ? spmq_pkg::KIND_DEQ : spmq_pkg::KIND_NOP;
      end
      spmq_pkg::OP_PRIO: begin
        cmd.kind = spmq_pkg::KIND_PRIO;
        cmd.line = '0;
      end
      default: begin
        // The unused opcode changes nothing and reports line zero.
        cmd.kind = spmq_pkg::KIND_NOP;
        cmd.line = '0;
      end
    endcase
  end

endmodule

@@ hdl/spmq_fifo.sv @@
// Small register FIFO used for the command queue and the result queue.
`timescale 1ns / 1ps

module spmq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [LW-1:0]    level_next;
  logic             do_push;
  logic             do_pop;

  assign full    = (level == LW'(DEPTH));
  assign empty   = (level == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_comb begin
    level_next = level;
    if (do_push && !do_pop) begin
      level_next = level + LW'(1);
    end else if (do_pop && !do_push) begin
      level_next = level - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      level <= level_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

@@ hdl/spmq_back.sv @@
// Execution engine: per-line pointers and counts, the ticket store and the result stage.
`timescale 1ns / 1ps

module spmq_back #(
  parameter int NUM_LINES   = spmq_pkg::NUM_LINES_DEF,
  parameter int LINE_DEPTH  = spmq_pkg::LINE_DEPTH_DEF,
  parameter int TICKET_BITS = spmq_pkg::TICKET_BITS_DEF,
  parameter int OUT_DEPTH   = spmq_pkg::OUT_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  spmq_pkg::cmd_t                 cmd,
  output logic                           cmd_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_level,
  output logic                           rsp_push,
  output spmq_pkg::rsp_t                 rsp
);

  localparam int LNW = $clog2(NUM_LINES);
  localparam int PW  = $clog2(LINE_DEPTH);
  localparam int CW  = $clog2(LINE_DEPTH+1);
  localparam int SLOTS = NUM_LINES * LINE_DEPTH;
  localparam int AW  = $clog2(SLOTS);
  localparam int TW  = $clog2(SLOTS+1);
  localparam int SW  = (TICKET_BITS < spmq_pkg::TICKET_W) ? TICKET_BITS : spmq_pkg::TICKET_W;
  localparam int OLW = $clog2(OUT_DEPTH+1);

  // Line state.
  logic [CW-1:0] cnt  [NUM_LINES];
  logic [PW-1:0] head [NUM_LINES];
  logic [PW-1:0] tail [NUM_LINES];
  logic [TW-1:0] total;

  // Ticket store, undefined until written.
  logic [SW-1:0] store [SLOTS];
  logic [SW-1:0] rd_data;

  // Result stage.
  logic                           b_valid;
  logic                           b_served;
  logic [spmq_pkg::LINE_SEL_W-1:0] b_line;
  logic                           b_ovf;
  logic [CW-1:0]                  b_lcnt;
  logic [TW-1:0]                  b_total;

  logic                           fire;
  logic [OLW:0]                   occupancy;
  logic [LNW-1:0]                 first_ln;
  logic [LNW+spmq_pkg::LINE_SEL_W-1:0] sel_wide;
  logic [LNW-1:0]                 ln;
  logic [CW-1:0]                  cur_cnt;
  logic                           is_enq;
  logic                           is_deq;
  logic                           line_full;
  logic                           do_enq;
  logic                           do_deq;
  logic                           ovf;
  logic [spmq_pkg::LINE_SEL_W+LNW-1:0] line_wide;
  logic [spmq_pkg::LINE_SEL_W-1:0] line_out;
  logic [CW-1:0]                  lcnt_out;
  logic [TW-1:0]                  total_next;
  logic [AW-1:0]                  wr_addr;
  logic [AW-1:0]                  rd_addr;
  logic [CW+spmq_pkg::LINE_COUNT_W-1:0]  lcnt_wide;
  logic [TW+spmq_pkg::TOTAL_COUNT_W-1:0] total_wide;
  logic [SW+spmq_pkg::TICKET_W-1:0]      ticket_wide;

  assign occupancy = (OLW+1)'(out_level) + (OLW+1)'(b_valid);
  assign fire      = cmd_valid && (occupancy < (OLW+1)'(OUT_DEPTH));
  assign cmd_pop   = fire;

  // Lowest numbered nonempty line; line zero when every line is empty.
  always_comb begin
    first_ln  = '0;
    for (int i = NUM_LINES-1; i >= 0; i--) begin
      if (cnt[i] != '0) begin
        first_ln  = LNW'(i);
      end
    end
  end

  assign sel_wide = {{LNW{1'b0}}, cmd.line};
  assign ln       = (cmd.kind == spmq_pkg::KIND_PRIO) ? first_ln : sel_wide[LNW-1:0];
  assign cur_cnt  = cnt[ln];
  assign is_enq   = (cmd.kind == spmq_pkg::KIND_ENQ);
  assign is_deq   = (cmd.kind == spmq_pkg::KIND_DEQ) || (cmd.kind == spmq_pkg::KIND_PRIO);
  assign line_full = (cur_cnt == CW'(LINE_DEPTH));
  assign ovf      = is_enq && line_full;
  assign do_enq   = fire && is_enq && !line_full;
  assign do_deq   = fire && is_deq && (cur_cnt != '0);

  assign line_wide = {{spmq_pkg::LINE_SEL_W{1'b0}}, first_ln};
  assign line_out  = (cmd.kind == spmq_pkg::KIND_PRIO) ? line_wide[spmq_pkg::LINE_SEL_W-1:0]
                                                       : cmd.line;

  always_comb begin
    lcnt_out   = '0;
    total_next = total;
    if (is_enq) begin
      lcnt_out = line_full ? cur_cnt : cur_cnt + CW'(1);
      if (!line_full) begin
        total_next = total + TW'(1);
      end
    end else if (is_deq && (cur_cnt != '0)) begin
      lcnt_out   = cur_cnt - CW'(1);
      total_next = total - TW'(1);
    end
  end

  assign wr_addr = AW'(ln) * AW'(LINE_DEPTH) + AW'(tail[ln]);
  assign rd_addr = AW'(ln) * AW'(LINE_DEPTH) + AW'(head[ln]);

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      for (int i = 0; i < NUM_LINES; i++) begin
        cnt[i]  <= '0;
        head[i] <= '0;
        tail[i] <= '0;
      end
    end else begin
      if (fire) begin
        total <= total_next;
      end
      if (do_enq) begin
        cnt[ln]  <= cur_cnt + CW'(1);
        tail[ln] <= (tail[ln] == PW'(LINE_DEPTH-1)) ? '0 : tail[ln] + PW'(1);
      end
      if (do_deq) begin
        cnt[ln]  <= cur_cnt - CW'(1);
        head[ln] <= (head[ln] == PW'(LINE_DEPTH-1)) ? '0 : head[ln] + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_enq) begin
      store[wr_addr] <= cmd.ticket[SW-1:0];
    end
    if (do_deq) begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b_served <= do_deq;
      b_line   <= line_out;
      b_ovf    <= ovf;
      b_lcnt   <= lcnt_out;
      b_total  <= total_next;
    end
  end

  assign lcnt_wide   = {{spmq_pkg::LINE_COUNT_W{1'b0}}, b_lcnt};
  assign total_wide  = {{spmq_pkg::TOTAL_COUNT_W{1'b0}}, b_total};
  assign ticket_wide = {{spmq_pkg::TICKET_W{1'b0}}, rd_data};

  assign rsp_push = b_valid;
  always_comb begin
    rsp.served_valid  = b_served;
    rsp.served_ticket = b_served ? ticket_wide[spmq_pkg::TICKET_W-1:0] : '0;
    rsp.served_line   = b_line;
    rsp.overflow      = b_ovf;
    rsp.line_count    = lcnt_wide[spmq_pkg::LINE_COUNT_W-1:0];
    rsp.total_count   = total_wide[spmq_pkg::TOTAL_COUNT_W-1:0];
  end

  // Checks on the line bookkeeping.
  logic [TW-1:0] count_sum;
  logic          any_over;

  always_comb begin
    count_sum = '0;
    any_over  = 1'b0;
    for (int i = 0; i < NUM_LINES; i++) begin
      count_sum = count_sum + TW'(cnt[i]);
      if (cnt[i] > CW'(LINE_DEPTH)) begin
        any_over = 1'b1;
      end
    end
  end

  a_total_matches: assert property (@(posedge clk) disable iff (rst) total == count_sum)
    else $error("running total differs from the sum of line counts");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst) !any_over)
    else $error("a line count exceeds the line depth");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst) fire |=> b_valid)
    else $error("an executed command produced no result");

  a_no_stray_result: assert property (@(posedge clk) disable iff (rst) !fire |=> !b_valid)
    else $error("a result appeared without an executed command");

  a_result_room: assert property (@(posedge clk) disable iff (rst)
      b_valid |-> (out_level != OLW'(OUT_DEPTH)))
    else $error("result pushed into a full result queue");

endmodule

@@ hdl/strict_priority_multi_queue_core.sv @@
// Top level of the strict priority multi queue: decoder, command queue, engine, result queue.
//
//   Channel   Direction  Handshake           Word
//   request   in         push / full         req (opcode, line_select, ticket)
//   result    out        pop / empty         rsp (served_valid ... total_count)
//
// One request word can be accepted every cycle, and the engine executes one command per
// cycle while the result queue has room, so the sustained rate is one word per cycle.
// A result word passes through the command queue and the registered read of the ticket
// store in the result stage, then it is written into the result queue.
// Reset is synchronous on rst and empties every line at once; the ticket store itself is
// never cleared, so the block is ready in the cycle after reset is released.
// When the consumer stops popping, the result queue fills, the engine stalls, the command
// queue fills and full rises; requests and results are never lost or duplicated.
`timescale 1ns / 1ps

module strict_priority_multi_queue_core #(
  parameter int NUM_LINES   = spmq_pkg::NUM_LINES_DEF,
  parameter int LINE_DEPTH  = spmq_pkg::LINE_DEPTH_DEF,
  parameter int TICKET_BITS = spmq_pkg::TICKET_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  spmq_pkg::req_t req,
  output logic           empty,
  input  logic           pop,
  output spmq_pkg::rsp_t rsp
);

  localparam int CMD_BITS = $bits(spmq_pkg::cmd_t);
  localparam int RSP_BITS = $bits(spmq_pkg::rsp_t);
  localparam int OLW      = $clog2(spmq_pkg::OUT_DEPTH+1);
  localparam int CLW      = $clog2(spmq_pkg::CMD_DEPTH+1);

  spmq_pkg::cmd_t cmd_in;
  spmq_pkg::cmd_t cmd_out;
  spmq_pkg::rsp_t rsp_in;
  logic [CMD_BITS-1:0] cmd_in_bits;
  logic [CMD_BITS-1:0] cmd_out_bits;
  logic [RSP_BITS-1:0] rsp_in_bits;
  logic [RSP_BITS-1:0] rsp_out_bits;
  logic                cmd_empty;
  logic                cmd_pop;
  logic [CLW-1:0]      cmd_level;
  logic                rsp_push;
  logic                rsp_full;
  logic [OLW-1:0]      out_level;

  // The front end sorts each word into enqueue, named dequeue, priority dequeue or
  // no-operation, settling the line range check before the word is queued.
  spmq_front #(
    .NUM_LINES(NUM_LINES)
  ) u_front (
    .req(req),
    .cmd(cmd_in)
  );

  assign cmd_in_bits = cmd_in;

  spmq_fifo #(
    .WIDTH(CMD_BITS),
    .DEPTH(spmq_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (cmd_in_bits),
    .full (full),
    .pop  (cmd_pop),
    .dout (cmd_out_bits),
    .empty(cmd_empty),
    .level(cmd_level)
  );

  assign cmd_out = spmq_pkg::cmd_t'(cmd_out_bits);

  // The engine only takes a command when the result queue is sure to have room for it,
  // counting the result still sitting in its own output stage.
  spmq_back #(
    .NUM_LINES  (NUM_LINES),
    .LINE_DEPTH (LINE_DEPTH),
    .TICKET_BITS(TICKET_BITS),
    .OUT_DEPTH  (spmq_pkg::OUT_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(!cmd_empty),
    .cmd      (cmd_out),
    .cmd_pop  (cmd_pop),
    .out_level(out_level),
    .rsp_push (rsp_push),
    .rsp      (rsp_in)
  );

  assign rsp_in_bits = rsp_in;

  spmq_fifo #(
    .WIDTH(RSP_BITS),
    .DEPTH(spmq_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (rsp_push),
    .din  (rsp_in_bits),
    .full (rsp_full),
    .pop  (pop),
    .dout (rsp_out_bits),
    .empty(empty),
    .level(out_level)
  );

  assign rsp = spmq_pkg::rsp_t'(rsp_out_bits);

  // Sanity checks across the two queues.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
      rsp_push |-> !rsp_full)
    else $error("engine wrote a result into a full result queue");

  a_cmd_level_bounded: assert property (@(posedge clk) disable iff (rst)
      cmd_level <= CLW'(spmq_pkg::CMD_DEPTH))
    else $error("command queue level out of range");

  a_pop_needs_command: assert property (@(posedge clk) disable iff (rst)
      cmd_pop |-> !cmd_empty)
    else $error("engine took a command from an empty command queue");

endmodule
